// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SLHW_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SLHW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/slhw_pkg.sv =====
`timescale 1ns / 1ps

package slhw_pkg;

    localparam int OWNER_W     = 8;
    localparam int GEN_W       = 32;
    localparam int TICK_IN_W   = 32;
    localparam int CNT_W       = 32;
    localparam int OPCODE_W    = 3;
    localparam int APB_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int TICK_WIDTH_DEF = 32;

    // register index taken from the word address
    localparam logic [CFG_ADDR_W-3:0] REG_STOP_RETRY = '0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_QUERY      = 3'd0,
        OP_BEGIN      = 3'd1,
        OP_HEARTBEAT  = 3'd2,
        OP_TMO_CLAIM  = 3'd3,
        OP_DISC_CLAIM = 3'd4,
        OP_STOP_RES   = 3'd5,
        OP_REVOKE     = 3'd6
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [OWNER_W-1:0]   owner_id;
        logic [GEN_W-1:0]     mode_gen;
        logic [GEN_W-1:0]     session_gen;
        logic [TICK_IN_W-1:0] tick_now;
        logic [TICK_IN_W-1:0] lease_timeout;
        logic                 was_stopped;
        logic                 owner_changed;
    } t_event;

    typedef struct packed {
        logic               granted;
        logic [OWNER_W-1:0] claimed_owner;
        logic [GEN_W-1:0]   claimed_mode_gen;
        logic [GEN_W-1:0]   claimed_session_gen;
        logic               lease_active;
        logic               stop_pending;
        logic [CNT_W-1:0]   timeouts_seen;
        logic [CNT_W-1:0]   disconnects_seen;
        logic [CNT_W-1:0]   retries_seen;
    } t_result;

endpackage

// ===== hdl/slhw_ifs.sv =====
`timescale 1ns / 1ps

// event channel into the supervisor
interface slhw_evt_if import slhw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [OWNER_W-1:0]   owner_id;
    logic [GEN_W-1:0]     mode_gen;
    logic [GEN_W-1:0]     session_gen;
    logic [TICK_IN_W-1:0] tick_now;
    logic [TICK_IN_W-1:0] lease_timeout;
    logic                 was_stopped;
    logic                 owner_changed;

    modport source (
        output valid, opcode, owner_id, mode_gen, session_gen, tick_now,
               lease_timeout, was_stopped, owner_changed,
        input  ready
    );
    modport sink (
        input  valid, opcode, owner_id, mode_gen, session_gen, tick_now,
               lease_timeout, was_stopped, owner_changed,
        output ready
    );
endinterface

// result channel out of the supervisor
interface slhw_res_if import slhw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               granted;
    logic [OWNER_W-1:0] claimed_owner;
    logic [GEN_W-1:0]   claimed_mode_gen;
    logic [GEN_W-1:0]   claimed_session_gen;
    logic               lease_active;
    logic               stop_pending;
    logic [CNT_W-1:0]   timeouts_seen;
    logic [CNT_W-1:0]   disconnects_seen;
    logic [CNT_W-1:0]   retries_seen;

    modport source (
        output valid, granted, claimed_owner, claimed_mode_gen, claimed_session_gen,
               lease_active, stop_pending, timeouts_seen, disconnects_seen,
               retries_seen,
        input  ready
    );
    modport sink (
        input  valid, granted, claimed_owner, claimed_mode_gen, claimed_session_gen,
               lease_active, stop_pending, timeouts_seen, disconnects_seen,
               retries_seen,
        output ready
    );
endinterface

// ===== hdl/session_lease_heartbeat_watchdog.sv =====
// session lease supervisor with heartbeat watchdog
// - i_evt carries one event per transfer (query, begin, heartbeat, timeout
//   claim, disconnect claim, stop result, revoke); o_res returns exactly one
//   result transfer per event, in order
// - the stop retry interval is written through the apb-style port at byte
//   address 0; pready is tied high, reads return the stored value
// - an accepted event passes through the input register, then the result
//   register, before it appears on o_res
// - throughput: one event per cycle while o_res does not stall; the lease
//   state is read and updated combinationally between the two registers, so
//   each event sees the state left by the one before it
// - a new event is taken while a finished result still waits on o_res, as
//   long as the input register is empty
// - when o_res stalls the result register holds, the input register fills
//   and then i_evt.ready drops until the result is taken
// - synchronous reset clears the lease, the stop latch, all counters, the
//   retry interval and both register valids
// - tick differences are taken modulo 2^TICK_WIDTH
`timescale 1ns / 1ps
`include "assert_macros.svh"

module session_lease_heartbeat_watchdog import slhw_pkg::*; #(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slhw_evt_if.sink              i_evt,
    slhw_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration
    logic [APB_DATA_W-1:0] r_retry_ivl;
    logic                  w_cfg_sel;

    // pipeline registers
    logic    r_in_vld;
    t_event  r_in;
    logic    r_out_vld;
    t_result r_out;

    // lease state
    logic                  r_active,     n_active;
    logic                  r_stop,       n_stop;
    logic                  r_attempt,    n_attempt;
    logic [OWNER_W-1:0]    r_held_owner, n_held_owner;
    logic [GEN_W-1:0]      r_held_mode,  n_held_mode;
    logic [GEN_W-1:0]      r_held_sess,  n_held_sess;
    logic [TICK_WIDTH-1:0] r_last_beat,  n_last_beat;
    logic [TICK_WIDTH-1:0] r_held_tmo,   n_held_tmo;
    logic [TICK_WIDTH-1:0] r_last_att,   n_last_att;
    logic [CNT_W-1:0]      r_tmo_cnt,    n_tmo_cnt;
    logic [CNT_W-1:0]      r_disc_cnt,   n_disc_cnt;
    logic [CNT_W-1:0]      r_retry_cnt,  n_retry_cnt;

    // handshake
    logic w_in_take;
    logic w_adv;
    logic w_fire;

    // event evaluation
    logic [TICK_WIDTH-1:0] w_now;
    logic [TICK_WIDTH-1:0] w_tmo;
    logic [TICK_WIDTH-1:0] w_retry;
    logic [TICK_WIDTH-1:0] w_beat_gap;
    logic [TICK_WIDTH-1:0] w_att_gap;
    logic                  w_may_begin;
    logic                  w_gap_over;
    logic                  w_claim_ok;
    t_result               n_res;

    // ------------------------------------------------------------------
    // apb-style register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_STOP_RETRY);
    assign prdata    = w_cfg_sel ? r_retry_ivl : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_ivl <= '0;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_retry_ivl <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // handshake: result register frees up when empty or being taken,
    // input register moves on whenever the result register can load
    // ------------------------------------------------------------------
    assign w_adv       = !r_out_vld || o_res.ready;
    assign w_fire      = r_in_vld && w_adv;
    assign i_evt.ready = !r_in_vld || w_adv;
    assign w_in_take   = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_in_take || (r_in_vld && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.opcode        <= i_evt.opcode;
            r_in.owner_id      <= i_evt.owner_id;
            r_in.mode_gen      <= i_evt.mode_gen;
            r_in.session_gen   <= i_evt.session_gen;
            r_in.tick_now      <= i_evt.tick_now;
            r_in.lease_timeout <= i_evt.lease_timeout;
            r_in.was_stopped   <= i_evt.was_stopped;
            r_in.owner_changed <= i_evt.owner_changed;
        end
    end

    // ------------------------------------------------------------------
    // tick arithmetic at the configured tick width
    // ------------------------------------------------------------------
    assign w_now      = TICK_WIDTH'(r_in.tick_now);
    assign w_tmo      = TICK_WIDTH'(r_in.lease_timeout);
    assign w_retry    = TICK_WIDTH'(r_retry_ivl);
    assign w_beat_gap = w_now - r_last_beat;
    assign w_att_gap  = w_now - r_last_att;
    assign w_gap_over = (w_beat_gap > r_held_tmo);
    // rate limit only applies once a claim has been handed out
    assign w_claim_ok = !r_attempt || (w_att_gap >= w_retry);

    // new owner needs a free lease, or must already hold an unlatched one
    assign w_may_begin = (r_in.owner_id != '0) && (r_in.session_gen != '0) &&
                         (!r_active || (!r_stop && (r_held_owner == r_in.owner_id) &&
                                        (r_held_sess == r_in.session_gen)));

    // ------------------------------------------------------------------
    // event evaluation
    // ------------------------------------------------------------------
    always_comb begin
        n_active     = r_active;
        n_stop       = r_stop;
        n_attempt    = r_attempt;
        n_held_owner = r_held_owner;
        n_held_mode  = r_held_mode;
        n_held_sess  = r_held_sess;
        n_last_beat  = r_last_beat;
        n_held_tmo   = r_held_tmo;
        n_last_att   = r_last_att;
        n_tmo_cnt    = r_tmo_cnt;
        n_disc_cnt   = r_disc_cnt;
        n_retry_cnt  = r_retry_cnt;
        n_res        = '0;

        unique case (t_opcode'(r_in.opcode))
            OP_QUERY: begin
                n_res.granted = w_may_begin;
            end
            OP_BEGIN: begin
                if ((r_in.mode_gen != '0) && (w_tmo != '0) && w_may_begin) begin
                    n_held_owner  = r_in.owner_id;
                    n_held_mode   = r_in.mode_gen;
                    n_held_sess   = r_in.session_gen;
                    n_last_beat   = w_now;
                    n_held_tmo    = w_tmo;
                    n_active      = 1'b1;
                    n_stop        = 1'b0;
                    n_attempt     = 1'b0;
                    n_res.granted = 1'b1;
                end
            end
            OP_HEARTBEAT: begin
                if (r_active && !r_stop && (r_held_owner == r_in.owner_id) &&
                    (r_held_mode == r_in.mode_gen) &&
                    (r_held_sess == r_in.session_gen)) begin
                    n_last_beat   = w_now;
                    n_res.granted = 1'b1;
                end
            end
            OP_TMO_CLAIM: begin
                // latch on an expired heartbeat gap, then try to hand out a claim
                if (r_active && (r_stop || w_gap_over)) begin
                    if (!r_stop) begin
                        n_stop    = 1'b1;
                        n_tmo_cnt = r_tmo_cnt + CNT_W'(1);
                    end
                    if (w_claim_ok) begin
                        n_last_att    = w_now;
                        n_attempt     = 1'b1;
                        n_res.granted = 1'b1;
                    end
                end
            end
            OP_DISC_CLAIM: begin
                if (r_active && (r_held_sess == r_in.session_gen)) begin
                    if (!r_stop) begin
                        n_stop     = 1'b1;
                        n_disc_cnt = r_disc_cnt + CNT_W'(1);
                    end
                    if (w_claim_ok) begin
                        n_last_att    = w_now;
                        n_attempt     = 1'b1;
                        n_res.granted = 1'b1;
                    end
                end
            end
            OP_STOP_RES: begin
                if (r_in.was_stopped || r_in.owner_changed) begin
                    n_active  = 1'b0;
                    n_stop    = 1'b0;
                    n_attempt = 1'b0;
                end else if (r_active && r_stop && r_attempt) begin
                    n_retry_cnt = r_retry_cnt + CNT_W'(1);
                end
            end
            OP_REVOKE: begin
                n_active  = 1'b0;
                n_stop    = 1'b0;
                n_attempt = 1'b0;
            end
            default: begin
                // unused opcode: status only
            end
        endcase

        // claimed fields only carry the lease on a granted claim
        if (n_res.granted && ((t_opcode'(r_in.opcode) == OP_TMO_CLAIM) ||
                              (t_opcode'(r_in.opcode) == OP_DISC_CLAIM))) begin
            n_res.claimed_owner       = r_held_owner;
            n_res.claimed_mode_gen    = r_held_mode;
            n_res.claimed_session_gen = r_held_sess;
        end

        n_res.lease_active     = n_active;
        n_res.stop_pending     = n_stop;
        n_res.timeouts_seen    = n_tmo_cnt;
        n_res.disconnects_seen = n_disc_cnt;
        n_res.retries_seen     = n_retry_cnt;
    end

    // ------------------------------------------------------------------
    // state update, one event per fire
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_stop       <= 1'b0;
            r_attempt    <= 1'b0;
            r_held_owner <= '0;
            r_held_mode  <= '0;
            r_held_sess  <= '0;
            r_last_beat  <= '0;
            r_held_tmo   <= '0;
            r_last_att   <= '0;
            r_tmo_cnt    <= '0;
            r_disc_cnt   <= '0;
            r_retry_cnt  <= '0;
        end else if (w_fire) begin
            r_active     <= n_active;
            r_stop       <= n_stop;
            r_attempt    <= n_attempt;
            r_held_owner <= n_held_owner;
            r_held_mode  <= n_held_mode;
            r_held_sess  <= n_held_sess;
            r_last_beat  <= n_last_beat;
            r_held_tmo   <= n_held_tmo;
            r_last_att   <= n_last_att;
            r_tmo_cnt    <= n_tmo_cnt;
            r_disc_cnt   <= n_disc_cnt;
            r_retry_cnt  <= n_retry_cnt;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_fire || (r_out_vld && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid               = r_out_vld;
    assign o_res.granted             = r_out.granted;
    assign o_res.claimed_owner       = r_out.claimed_owner;
    assign o_res.claimed_mode_gen    = r_out.claimed_mode_gen;
    assign o_res.claimed_session_gen = r_out.claimed_session_gen;
    assign o_res.lease_active        = r_out.lease_active;
    assign o_res.stop_pending        = r_out.stop_pending;
    assign o_res.timeouts_seen       = r_out.timeouts_seen;
    assign o_res.disconnects_seen    = r_out.disconnects_seen;
    assign o_res.retries_seen        = r_out.retries_seen;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SLHW_ASSERT(a_stop_needs_lease, i_clk, i_rst_n, !r_stop || r_active, "stop latched without an active lease")
    `SLHW_ASSERT(a_attempt_needs_stop, i_clk, i_rst_n, !r_attempt || r_stop, "claim recorded without a latched stop")
    `SLHW_ASSERT_IMP(a_claim_fields_zero, i_clk, i_rst_n, r_out_vld && !r_out.granted, (r_out.claimed_owner == '0) && (r_out.claimed_mode_gen == '0), "claim fields set on a refused event")
    `SLHW_ASSERT_IMP(a_tmo_cnt_step, i_clk, i_rst_n, r_tmo_cnt != $past(r_tmo_cnt), r_tmo_cnt == $past(r_tmo_cnt) + 1'b1, "timeout counter moved by other than one")

endmodule
